/* rtl/core/clr_pkg.sv */
// Shared types and constants for the climate relay controller.
// Holds the item layout, channel status, register codes and the condensation band rule.
// No dependencies.
`timescale 1ns / 1ps

package clr_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int NUM_PAIRS    = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;

    localparam logic signed [11:0] COND_T_SET      = 12'sd50;
    localparam logic signed [11:0] COND_T_MID      = 12'sd250;
    localparam logic signed [11:0] COND_T_HIGH     = 12'sd380;
    localparam logic signed [11:0] COND_H_SET_MID  = 12'sd650;
    localparam logic signed [11:0] COND_H_SET_HIGH = 12'sd750;
    localparam logic signed [11:0] COND_H_CLEAR    = 12'sd500;

    localparam logic [7:0] FAULT_READS = 8'd10;

    localparam logic signed [15:0] RUN_MAX = 16'sh7FFF;
    localparam logic signed [15:0] RUN_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_WARM_MODE       = 3'd0,
        CFG_TEMP_ON_LEVEL        = 3'd1,
        CFG_TEMP_OFF_LEVEL       = 3'd2,
        CFG_HUM_ON_LEVEL         = 3'd3,
        CFG_HUM_OFF_LEVEL        = 3'd4,
        CFG_CONDENSATION_ENABLE  = 3'd5,
        CFG_LOAD_OK_LEVEL        = 3'd6,
        CFG_SECOND_ALARM_DISABLE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [11:0] temp_a;
        logic signed [11:0] hum_a;
        logic signed [11:0] temp_b;
        logic signed [11:0] hum_b;
        logic [9:0]         load_a_temp;
        logic [9:0]         load_a_hum;
        logic [9:0]         load_b_temp;
        logic [9:0]         load_b_hum;
        logic [7:0]         bad_reads_a;
        logic [7:0]         bad_reads_b;
        logic               toggle_manual;
        logic               blink_phase;
    } t_item;

    typedef struct packed {
        logic on;
        logic alarm;
    } t_chan_status;

    function automatic logic cond_next(logic signed [11:0] t, logic signed [11:0] h,
                                       logic cur);
        logic n;
        n = cur;
        if (t <= COND_T_SET) begin
            n = 1'b1;
        end else if (t <= COND_T_MID) begin
            if (h >= COND_H_SET_MID) n = 1'b1;
            else if (h <= COND_H_CLEAR) n = 1'b0;
        end else if (t <= COND_T_HIGH) begin
            if (h >= COND_H_SET_HIGH) n = 1'b1;
            else if (h <= COND_H_CLEAR) n = 1'b0;
        end else begin
            n = 1'b0;
        end
        return n;
    endfunction

endpackage

/* rtl/core/climate_relay_controller_top.sv */
// Top level of the climate relay controller: input register, tick evaluation, result register.
// Depends on clr_pkg and clr_channel.
`timescale 1ns / 1ps

// Takes one control tick per clock cycle while the output side does not stall and returns
// one result beat per tick; each tick passes through the input register and then the result
// register, and the state (manual mode, condensation flags, channel states, run counters)
// is updated as a tick moves from the input register into the result register.
// Configuration writes are always taken and must only be issued while no tick is in flight.
module climate_relay_controller_top #(
    parameter int TICKS_PER_SECOND = 50,
    parameter int BAD_READ_LIMIT   = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [clr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [11:0]                i_temp_a,
    input  logic signed [11:0]                i_hum_a,
    input  logic signed [11:0]                i_temp_b,
    input  logic signed [11:0]                i_hum_b,
    input  logic [9:0]                        i_load_a_temp,
    input  logic [9:0]                        i_load_a_hum,
    input  logic [9:0]                        i_load_b_temp,
    input  logic [9:0]                        i_load_b_hum,
    input  logic [7:0]                        i_bad_reads_a,
    input  logic [7:0]                        i_bad_reads_b,
    input  logic                              i_toggle_manual,
    input  logic                              i_blink_phase,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [3:0]                        o_relays,
    output logic [3:0]                        o_leds,
    output logic [3:0]                        o_load_alarms,
    output logic                              o_summary_alarm,
    output logic                              o_manual_active
);
    import clr_pkg::*;

    localparam int         ALARM_TICKS = 3 * TICKS_PER_SECOND;
    localparam logic [7:0] BAD_LIMIT   = 8'(BAD_READ_LIMIT);

    logic               r_warm, r_cond_en, r_dis2;
    logic signed [11:0] r_ton, r_toff, r_hon, r_hoff;
    logic [9:0]         r_load_ok;

    logic               r_in_valid;
    t_item              r_in;
    logic               advance;

    logic               r_manual, n_manual;
    logic [NUM_PAIRS-1:0] r_cond, n_cond;

    logic signed [11:0] val    [NUM_CHANNELS];
    logic [9:0]         load   [NUM_CHANNELS];
    logic [7:0]         bad    [NUM_PAIRS];
    t_chan_status       status [NUM_CHANNELS];

    logic [3:0]         n_relays, n_leds, n_alarms;
    logic               n_summary;

    logic               r_out_valid;
    logic [3:0]         r_relays, r_leds, r_alarms;
    logic               r_summary, r_manual_out;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm    <= 1'b0;
            r_ton     <= 12'sd700;
            r_toff    <= 12'sd300;
            r_hon     <= 12'sd800;
            r_hoff    <= 12'sd400;
            r_cond_en <= 1'b0;
            r_load_ok <= 10'd512;
            r_dis2    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_WARM_MODE:       r_warm    <= i_cfg_data[0];
                CFG_TEMP_ON_LEVEL:        r_ton     <= i_cfg_data;
                CFG_TEMP_OFF_LEVEL:       r_toff    <= i_cfg_data;
                CFG_HUM_ON_LEVEL:         r_hon     <= i_cfg_data;
                CFG_HUM_OFF_LEVEL:        r_hoff    <= i_cfg_data;
                CFG_CONDENSATION_ENABLE:  r_cond_en <= i_cfg_data[0];
                CFG_LOAD_OK_LEVEL:        r_load_ok <= i_cfg_data[9:0];
                CFG_SECOND_ALARM_DISABLE: r_dis2    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.temp_a        <= i_temp_a;
            r_in.hum_a         <= i_hum_a;
            r_in.temp_b        <= i_temp_b;
            r_in.hum_b         <= i_hum_b;
            r_in.load_a_temp   <= i_load_a_temp;
            r_in.load_a_hum    <= i_load_a_hum;
            r_in.load_b_temp   <= i_load_b_temp;
            r_in.load_b_hum    <= i_load_b_hum;
            r_in.bad_reads_a   <= i_bad_reads_a;
            r_in.bad_reads_b   <= i_bad_reads_b;
            r_in.toggle_manual <= i_toggle_manual;
            r_in.blink_phase   <= i_blink_phase;
        end
    end

    // tick evaluation
    always_comb begin
        val[0]  = r_in.temp_a;
        val[1]  = r_in.hum_a;
        val[2]  = r_in.temp_b;
        val[3]  = r_in.hum_b;
        load[0] = r_in.load_a_temp;
        load[1] = r_in.load_a_hum;
        load[2] = r_in.load_b_temp;
        load[3] = r_in.load_b_hum;
        bad[0]  = r_in.bad_reads_a;
        bad[1]  = r_in.bad_reads_b;
        n_manual  = r_manual ^ r_in.toggle_manual;
        n_cond[0] = cond_next(r_in.temp_a, r_in.hum_a, r_cond[0]);
        n_cond[1] = cond_next(r_in.temp_b, r_in.hum_b, r_cond[1]);
    end

    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
        localparam bit IS_TEMP = (k % 2) == 0;

        clr_channel #(
            .ALARM_TICKS (ALARM_TICKS)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_value     (val[k]),
            .i_on_level  (IS_TEMP ? r_ton  : r_hon),
            .i_off_level (IS_TEMP ? r_toff : r_hoff),
            .i_warm      (IS_TEMP ? r_warm : 1'b0),
            .i_force     ((n_cond[k/2] && r_cond_en) || n_manual),
            .i_load      (load[k]),
            .i_load_ok   (r_load_ok),
            .o_status    (status[k])
        );

        always_comb begin
            n_relays[k] = ((bad[k/2] <= BAD_LIMIT) && status[k].on) || n_manual;
            n_alarms[k] = status[k].alarm;
            n_leds[k]   = n_relays[k] && !(status[k].alarm && r_in.blink_phase);
        end
    end

    assign n_summary = (bad[0] > FAULT_READS) || (|n_alarms[1:0]) ||
                       (!r_dis2 && ((bad[1] > FAULT_READS) || (|n_alarms[3:2])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual <= 1'b0;
            r_cond   <= '0;
        end else if (advance) begin
            r_manual <= n_manual;
            r_cond   <= n_cond;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_relays     <= n_relays;
            r_leds       <= n_leds;
            r_alarms     <= n_alarms;
            r_summary    <= n_summary;
            r_manual_out <= n_manual;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relays        = r_relays;
    assign o_leds          = r_leds;
    assign o_load_alarms   = r_alarms;
    assign o_summary_alarm = r_summary;
    assign o_manual_active = r_manual_out;

    a_manual_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_manual_active |-> o_relays == 4'hF)
        else $error("manual mode beat without all relays on");

    a_leds_follow_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_leds & ~o_relays) == 4'h0)
        else $error("LED lit on a channel whose relay is off");

    a_pair_a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_load_alarms[1:0] != 2'b00) |-> o_summary_alarm)
        else $error("first pair load alarm without summary alarm");

    a_hold_stalled_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("stalled tick lost from the input register");

endmodule

/* rtl/core/clr_channel.sv */
// One relay channel: hysteresis on/off state, saturating run counter and load alarm.
// Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_channel #(
    parameter int ALARM_TICKS = 150
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic signed [11:0]        i_value,
    input  logic signed [11:0]        i_on_level,
    input  logic signed [11:0]        i_off_level,
    input  logic                      i_warm,
    input  logic                      i_force,
    input  logic [9:0]                i_load,
    input  logic [9:0]                i_load_ok,
    output clr_pkg::t_chan_status     o_status
);
    import clr_pkg::*;

    localparam logic signed [15:0] ALARM_LEVEL = 16'(ALARM_TICKS);

    logic               r_on, n_on;
    logic signed [15:0] r_run, n_run;
    logic               on_c, off_c;

    always_comb begin
        on_c  = i_warm ? (i_value <= i_on_level)  : (i_value >= i_on_level);
        off_c = i_warm ? (i_value >= i_off_level) : (i_value <= i_off_level);
        n_on  = r_on;
        n_run = r_run;
        if (on_c || i_force) begin
            n_on = 1'b1;
            if (r_run != RUN_MAX) n_run = r_run + 16'sd1;
        end else if (off_c) begin
            n_on = 1'b0;
            if (r_run != RUN_MIN) n_run = r_run - 16'sd1;
        end
    end

    assign o_status.on    = n_on;
    assign o_status.alarm = (n_run > ALARM_LEVEL) && (i_load > i_load_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= 1'b0;
            r_run <= '0;
        end else if (i_advance) begin
            r_on  <= n_on;
            r_run <= n_run;
        end
    end

endmodule

/* tb/climate_relay_controller_top_tb.sv */
// Self-checking testbench for climate_relay_controller_top: directed ticks, counter soak and
// random phases over several register settings, checked beat by beat against a local model.
// Depends on clr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module climate_relay_controller_top_tb;
    import clr_pkg::*;

    localparam int TICKS_PER_SECOND = 50;
    localparam int BAD_READ_LIMIT   = 3;
    localparam int SOAK_DOWN        = 250;
    localparam int SOAK_UP          = 500;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int TAIL_CYCLES      = 10;
    localparam int LIMIT_NS         = 10_000_000;

    typedef struct packed {
        logic [3:0] relays;
        logic [3:0] leds;
        logic [3:0] load_alarms;
        logic       summary_alarm;
        logic       manual_active;
    } t_tick_result;

    typedef struct {
        t_item        item;
        bit           pinned;
        t_tick_result res;
    } t_stim_row;

    localparam t_tick_result NO_RES = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index;
    logic [11:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_item                tick_in;
    logic                 tick_pinned;
    t_tick_result         tick_pinned_res;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [3:0]           o_relays;
    logic [3:0]           o_leds;
    logic [3:0]           o_load_alarms;
    logic                 o_summary_alarm;
    logic                 o_manual_active;

    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   mismatch_cnt = 0;
    t_tick_result         queued_outputs[$];
    logic [11:0]          reg_plan[8];

    // Local copy of the block's registers and state
    logic                 cfg_warm = 1'b0;
    logic signed [11:0]   cfg_temp_on = 12'sd700;
    logic signed [11:0]   cfg_temp_off = 12'sd300;
    logic signed [11:0]   cfg_hum_on = 12'sd800;
    logic signed [11:0]   cfg_hum_off = 12'sd400;
    logic                 cfg_cond_en = 1'b0;
    logic [9:0]           cfg_load_ok = 10'd512;
    logic                 cfg_pair_b_quiet = 1'b0;
    logic                 cond_flag[2] = '{1'b0, 1'b0};
    logic                 chan_on[4] = '{1'b0, 1'b0, 1'b0, 1'b0};
    logic signed [15:0]   run_cnt[4] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    logic                 manual_on = 1'b0;

    climate_relay_controller_top #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .BAD_READ_LIMIT   (BAD_READ_LIMIT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_temp_a        (tick_in.temp_a),
        .i_hum_a         (tick_in.hum_a),
        .i_temp_b        (tick_in.temp_b),
        .i_hum_b         (tick_in.hum_b),
        .i_load_a_temp   (tick_in.load_a_temp),
        .i_load_a_hum    (tick_in.load_a_hum),
        .i_load_b_temp   (tick_in.load_b_temp),
        .i_load_b_hum    (tick_in.load_b_hum),
        .i_bad_reads_a   (tick_in.bad_reads_a),
        .i_bad_reads_b   (tick_in.bad_reads_b),
        .i_toggle_manual (tick_in.toggle_manual),
        .i_blink_phase   (tick_in.blink_phase),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_relays        (o_relays),
        .o_leds          (o_leds),
        .o_load_alarms   (o_load_alarms),
        .o_summary_alarm (o_summary_alarm),
        .o_manual_active (o_manual_active)
    );

    always #5 i_clk = ~i_clk;

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_item mk_tick(int ta, int ha, int tb, int hb, int ld, int ba, int bb,
                                      int tog, int blink);
        t_item it;
        it.temp_a        = 12'(ta);
        it.hum_a         = 12'(ha);
        it.temp_b        = 12'(tb);
        it.hum_b         = 12'(hb);
        it.load_a_temp   = 10'(ld);
        it.load_a_hum    = 10'(ld);
        it.load_b_temp   = 10'(ld);
        it.load_b_hum    = 10'(ld);
        it.bad_reads_a   = 8'(ba);
        it.bad_reads_b   = 8'(bb);
        it.toggle_manual = 1'(tog);
        it.blink_phase   = 1'(blink);
        return it;
    endfunction

    function automatic t_tick_result run_control_tick(t_item it);
        logic signed [11:0] val[4];
        logic [9:0]         load[4];
        logic [7:0]         bad[2];
        logic signed [11:0] t, h, on_lv, off_lv;
        logic               warm, on_c, off_c, alarm, relay;
        t_tick_result       r;
        int                 p, k;
        val[0]  = it.temp_a;
        val[1]  = it.hum_a;
        val[2]  = it.temp_b;
        val[3]  = it.hum_b;
        load[0] = it.load_a_temp;
        load[1] = it.load_a_hum;
        load[2] = it.load_b_temp;
        load[3] = it.load_b_hum;
        bad[0]  = it.bad_reads_a;
        bad[1]  = it.bad_reads_b;
        r = '0;
        if (it.toggle_manual) manual_on = !manual_on;
        for (p = 0; p < 2; p++) begin
            t = val[2 * p];
            h = val[2 * p + 1];
            if (t <= COND_T_SET) begin
                cond_flag[p] = 1'b1;
            end else if (t <= COND_T_MID) begin
                if (h >= COND_H_SET_MID) cond_flag[p] = 1'b1;
                if (h <= COND_H_CLEAR) cond_flag[p] = 1'b0;
            end else if (t <= COND_T_HIGH) begin
                if (h >= COND_H_SET_HIGH) cond_flag[p] = 1'b1;
                if (h <= COND_H_CLEAR) cond_flag[p] = 1'b0;
            end else begin
                cond_flag[p] = 1'b0;
            end
        end
        for (k = 0; k < 4; k++) begin
            if (k % 2 == 0) begin
                warm   = cfg_warm;
                on_lv  = cfg_temp_on;
                off_lv = cfg_temp_off;
            end else begin
                warm   = 1'b0;
                on_lv  = cfg_hum_on;
                off_lv = cfg_hum_off;
            end
            on_c  = warm ? (val[k] <= on_lv) : (val[k] >= on_lv);
            off_c = warm ? (val[k] >= off_lv) : (val[k] <= off_lv);
            if (on_c || (cond_flag[k / 2] && cfg_cond_en) || manual_on) begin
                chan_on[k] = 1'b1;
                if (run_cnt[k] != RUN_MAX) run_cnt[k] = run_cnt[k] + 16'sd1;
            end else if (off_c) begin
                chan_on[k] = 1'b0;
                if (run_cnt[k] != RUN_MIN) run_cnt[k] = run_cnt[k] - 16'sd1;
            end
            alarm = (run_cnt[k] > 3 * TICKS_PER_SECOND) && (load[k] > cfg_load_ok);
            relay = ((bad[k / 2] <= BAD_READ_LIMIT) && chan_on[k]) || manual_on;
            r.relays[k]      = relay;
            r.leds[k]        = relay && !(alarm && it.blink_phase);
            r.load_alarms[k] = alarm;
        end
        r.summary_alarm = (bad[0] > FAULT_READS) || (|r.load_alarms[1:0]) ||
                          (!cfg_pair_b_quiet && ((bad[1] > FAULT_READS) ||
                                                 (|r.load_alarms[3:2])));
        r.manual_active = manual_on;
        return r;
    endfunction

    task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP_WARM_MODE:       cfg_warm = i_cfg_data[0];
                    CFG_TEMP_ON_LEVEL:        cfg_temp_on = i_cfg_data;
                    CFG_TEMP_OFF_LEVEL:       cfg_temp_off = i_cfg_data;
                    CFG_HUM_ON_LEVEL:         cfg_hum_on = i_cfg_data;
                    CFG_HUM_OFF_LEVEL:        cfg_hum_off = i_cfg_data;
                    CFG_CONDENSATION_ENABLE:  cfg_cond_en = i_cfg_data[0];
                    CFG_LOAD_OK_LEVEL:        cfg_load_ok = i_cfg_data[9:0];
                    CFG_SECOND_ALARM_DISABLE: cfg_pair_b_quiet = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = run_control_tick(tick_in);
                queued_outputs.push_back(tick_pinned ? tick_pinned_res : want);
            end
            if (o_out_valid && i_out_ready) begin
                if (queued_outputs.size() == 0) begin
                    $error("result beat with no tick outstanding");
                    mismatch_cnt++;
                end else begin
                    want = queued_outputs.pop_front();
                    compare_field("relays", want.relays, o_relays);
                    compare_field("leds", want.leds, o_leds);
                    compare_field("load_alarms", want.load_alarms, o_load_alarms);
                    compare_field("summary_alarm", 4'(want.summary_alarm), 4'(o_summary_alarm));
                    compare_field("manual_active", 4'(want.manual_active), 4'(o_manual_active));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_tick(t_item it, bit pinned, t_tick_result res);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        tick_in         <= it;
        tick_pinned     <= pinned;
        tick_pinned_res <= res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (queued_outputs.size() != 0);
    endtask

    task automatic load_registers();
        for (int r = 0; r < $size(reg_plan); r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(r);
            i_cfg_data  <= reg_plan[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_defaults();
        reg_plan[CFG_TEMP_WARM_MODE]       = 12'd0;
        reg_plan[CFG_TEMP_ON_LEVEL]        = 12'd700;
        reg_plan[CFG_TEMP_OFF_LEVEL]       = 12'd300;
        reg_plan[CFG_HUM_ON_LEVEL]         = 12'd800;
        reg_plan[CFG_HUM_OFF_LEVEL]        = 12'd400;
        reg_plan[CFG_CONDENSATION_ENABLE]  = 12'd0;
        reg_plan[CFG_LOAD_OK_LEVEL]        = 12'd512;
        reg_plan[CFG_SECOND_ALARM_DISABLE] = 12'd0;
    endtask

    initial begin
        t_stim_row directed_rows[$];
        int        cond_row_start;
        int        i, n, c, seg_len, ld_centre;
        int        centre[4];
        int        bad_seg[2];
        t_item     it;
        logic [127:0] noise;

        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_TEMP_WARM_MODE;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        tick_in         <= '0;
        tick_pinned     <= 1'b0;
        tick_pinned_res <= '0;
        i_out_ready     <= 1'b0;
        plan_defaults();

        // Rows under reset settings: results typed in
        directed_rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NO_RES});
        directed_rows.push_back('{mk_tick(2047, 2047, 2047, 2047, 1023, 0, 0, 0, 1), 1'b1,
                                  '{4'hF, 4'hF, 4'h0, 1'b0, 1'b0}});
        directed_rows.push_back('{mk_tick(2047, 2047, 2047, 2047, 1023, 4, 3, 0, 1), 1'b1,
                                  '{4'hC, 4'hC, 4'h0, 1'b0, 1'b0}});
        directed_rows.push_back('{mk_tick(2047, 2047, 2047, 2047, 1023, 10, 11, 0, 0), 1'b1,
                                  '{4'h0, 4'h0, 4'h0, 1'b1, 1'b0}});
        directed_rows.push_back('{mk_tick(-2048, -2048, -2048, -2048, 0, 255, 255, 1, 1), 1'b1,
                                  '{4'hF, 4'hF, 4'h0, 1'b1, 1'b1}});
        directed_rows.push_back('{mk_tick(-2048, -2048, -2048, -2048, 1023, 0, 0, 0, 1), 1'b1,
                                  '{4'hF, 4'hF, 4'h0, 1'b0, 1'b1}});
        directed_rows.push_back('{mk_tick(-2048, -2048, -2048, -2048, 0, 0, 0, 1, 0), 1'b1,
                                  NO_RES});
        // Condensation bands and hysteresis edges, condensation forcing enabled
        cond_row_start = directed_rows.size();
        directed_rows.push_back('{mk_tick(50, 0, 51, 649, 600, 0, 0, 0, 1), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(250, 650, 251, 749, 100, 2, 3, 0, 0), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(250, 500, 380, 750, 513, 0, 0, 0, 1), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(251, 501, 381, 2047, 512, 0, 0, 0, 0), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(380, 501, 300, 750, 700, 1, 0, 0, 1), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(500, 401, 700, 800, 900, 0, 1, 0, 0), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(700, 800, 301, 400, 300, 3, 4, 0, 1), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(300, 400, -1, 2047, 1023, 0, 0, 0, 1), 1'b0, NO_RES});
        directed_rows.push_back('{mk_tick(2047, -2048, 2047, 2047, 0, 0, 0, 0, 0), 1'b0,
                                  NO_RES});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct   = 15;
        stall_pct = 15;

        foreach (directed_rows[r]) begin
            if (r == cond_row_start) begin
                wait_all_results();
                reg_plan[CFG_CONDENSATION_ENABLE] = 12'd1;
                load_registers();
            end
            send_tick(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].res);
        end

        // Drive every run counter well below zero, then up past the alarm level
        wait_all_results();
        plan_defaults();
        load_registers();
        gap_pct   = 0;
        stall_pct = 0;
        for (i = 0; i < SOAK_DOWN + SOAK_UP; i++) begin
            if (i < SOAK_DOWN)
                it = mk_tick(rand_between(-2048, 300), rand_between(-2048, 400),
                             rand_between(-2048, 300), rand_between(-2048, 400),
                             $urandom_range(0, 1023), $urandom_range(0, 255),
                             $urandom_range(0, 255), 0, $urandom_range(0, 1));
            else
                it = mk_tick(rand_between(700, 2047), rand_between(800, 2047),
                             rand_between(700, 2047), rand_between(800, 2047),
                             $urandom_range(0, 1023), $urandom_range(0, 255),
                             $urandom_range(0, 255), 0, $urandom_range(0, 1));
            send_tick(it, 1'b0, NO_RES);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_all_results();
            case (ph)
                0: begin
                    reg_plan[CFG_TEMP_WARM_MODE]       = 12'd1;
                    reg_plan[CFG_TEMP_ON_LEVEL]        = 12'h800;
                    reg_plan[CFG_TEMP_OFF_LEVEL]       = 12'h7FF;
                    reg_plan[CFG_HUM_ON_LEVEL]         = 12'h7FF;
                    reg_plan[CFG_HUM_OFF_LEVEL]        = 12'h800;
                    reg_plan[CFG_CONDENSATION_ENABLE]  = 12'd0;
                    reg_plan[CFG_LOAD_OK_LEVEL]        = 12'd0;
                    reg_plan[CFG_SECOND_ALARM_DISABLE] = 12'd1;
                end
                1: begin
                    reg_plan[CFG_TEMP_WARM_MODE]       = 12'd0;
                    reg_plan[CFG_TEMP_ON_LEVEL]        = 12'h7FF;
                    reg_plan[CFG_TEMP_OFF_LEVEL]       = 12'h800;
                    reg_plan[CFG_HUM_ON_LEVEL]         = 12'h800;
                    reg_plan[CFG_HUM_OFF_LEVEL]        = 12'h7FF;
                    reg_plan[CFG_CONDENSATION_ENABLE]  = 12'd1;
                    reg_plan[CFG_LOAD_OK_LEVEL]        = 12'd1023;
                    reg_plan[CFG_SECOND_ALARM_DISABLE] = 12'd0;
                end
                default: begin
                    reg_plan[CFG_TEMP_WARM_MODE] = 12'($urandom_range(0, 1));
                    for (int r = CFG_TEMP_ON_LEVEL; r <= CFG_HUM_OFF_LEVEL; r++)
                        reg_plan[r] = $urandom_range(0, 1) ? 12'($urandom)
                                                           : 12'(rand_between(-200, 1200));
                    reg_plan[CFG_CONDENSATION_ENABLE]  = 12'($urandom_range(0, 1));
                    reg_plan[CFG_LOAD_OK_LEVEL]        = $urandom_range(0, 1)
                                                         ? 12'($urandom_range(0, 1023))
                                                         : 12'($urandom_range(300, 700));
                    reg_plan[CFG_SECOND_ALARM_DISABLE] = 12'($urandom_range(0, 1));
                end
            endcase
            load_registers();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 69; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 69; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // Hover each channel near a threshold, a band edge or a random centre for a while
                seg_len = $urandom_range(4, 60);
                for (c = 0; c < 4; c++) begin
                    case ($urandom_range(0, 5))
                        0: centre[c] = (c % 2 == 0) ? $signed(reg_plan[CFG_TEMP_ON_LEVEL])
                                                    : $signed(reg_plan[CFG_HUM_ON_LEVEL]);
                        1: centre[c] = (c % 2 == 0) ? $signed(reg_plan[CFG_TEMP_OFF_LEVEL])
                                                    : $signed(reg_plan[CFG_HUM_OFF_LEVEL]);
                        2: centre[c] = (c % 2 == 0) ? int'(COND_T_SET) : int'(COND_H_CLEAR);
                        3: centre[c] = (c % 2 == 0) ? int'(COND_T_MID) : int'(COND_H_SET_MID);
                        4: centre[c] = (c % 2 == 0) ? int'(COND_T_HIGH) : int'(COND_H_SET_HIGH);
                        default: centre[c] = rand_between(-2048, 2047);
                    endcase
                end
                ld_centre  = $urandom_range(0, 1) ? int'(reg_plan[CFG_LOAD_OK_LEVEL][9:0])
                                                  : int'($urandom_range(0, 1023));
                bad_seg[0] = $urandom_range(0, 12);
                bad_seg[1] = $urandom_range(0, 12);
                for (i = 0; i < seg_len && n < ITEMS_PER_PHASE; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        noise = {$urandom, $urandom, $urandom, $urandom};
                        it = noise[$bits(t_item)-1:0];
                    end else begin
                        it = mk_tick(centre[0] + rand_between(-8, 8),
                                     centre[1] + rand_between(-8, 8),
                                     centre[2] + rand_between(-8, 8),
                                     centre[3] + rand_between(-8, 8),
                                     ld_centre + rand_between(-4, 4),
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                 : bad_seg[0],
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                 : bad_seg[1],
                                     $urandom_range(0, 24) == 0, $urandom_range(0, 1));
                    end
                    send_tick(it, 1'b0, NO_RES);
                    n++;
                end
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/clr_pkg.sv
rtl/core/clr_channel.sv
rtl/core/climate_relay_controller_top.sv
tb/climate_relay_controller_top_tb.sv
